// ----- src/i2cbm_pkg.sv -----
// shared types and constants for the i2c register burst master
package i2cbm_pkg;

    localparam int unsigned BUF_SLOTS = 8;
    localparam int unsigned BUF_AW    = $clog2(BUF_SLOTS);

    localparam logic [6:0]  DEV_ADDR_RST   = 7'd104;
    localparam logic [15:0] RETRY_LIM_RST  = 16'd1000;
    localparam logic [15:0] ACK_WAIT_RST   = 16'd5000;
    localparam logic [7:0]  TPP_RST        = 8'd1;

    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_LOAD  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        CFG_DEV_ADDR  = 2'd0,
        CFG_RETRY_LIM = 2'd1,
        CFG_ACK_WAIT  = 2'd2,
        CFG_TPP       = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE    = 4'd0,
        ST_START1  = 4'd1,
        ST_TXADDR  = 4'd2,
        ST_TXREG   = 4'd3,
        ST_START2  = 4'd4,
        ST_TXRADDR = 4'd5,
        ST_TXDATA  = 4'd6,
        ST_RXDATA  = 4'd7,
        ST_STOP    = 4'd8
    } seq_state_t;

    typedef struct packed {
        logic [6:0]  dev_addr;
        logic [15:0] retry_lim;
        logic [15:0] ack_wait_lim;
        logic [7:0]  tpp;
    } cfg_t;

    typedef struct packed {
        func_t       func;
        logic [7:0]  reg_addr;
        logic [3:0]  count;
        logic [2:0]  byte_index;
        logic [7:0]  byte_value;
        logic        sda_in;
    } item_t;

    typedef struct packed {
        logic        scl_level;
        logic        sda_pull_low;
        logic        busy_res;
        logic        read_valid;
        logic [2:0]  read_index;
        logic [7:0]  read_byte;
        logic        done_res;
        logic        status;
    } res_t;

endpackage

// ----- src/i2c_register_burst_master.sv -----
// top level of the i2c register burst master: config registers and channel wiring
//
// Input channel (s_*): each item is one command. func tick advances the bus
// sequencer by one tick and carries the sampled SDA level; begin write / begin
// read start a burst of count bytes at reg_addr; load stores byte_value into
// transmit buffer slot byte_index. Result channel (m_*): one item per input
// item, carrying the SCL level and SDA pull-down for that tick, busy, a
// completed read byte, and done with its status.
// Config port: cfg_wr_en, cfg_index and cfg_wdata write device address,
// address retry limit, acknowledge wait limit and ticks per phase; write
// only while no burst runs.
// Result: the result of an item is registered and on m_* in the cycle after it is accepted.
// Throughput: one item per cycle while results are taken; the per-item logic sits between the
// sequencer state registers and the result register.
// Reset: sequencer goes idle, result register empties, config returns to
// its defaults; buffer contents are kept until loaded.
// Stall: with a result held and m_ready low, s_ready drops; it rises again
// in the cycle the held result is taken.
module i2c_register_burst_master
    import i2cbm_pkg::*;
#(
    parameter int unsigned MAX_BURST = 8
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [7:0]  s_reg_addr,
    input  logic [3:0]  s_count,
    input  logic [2:0]  s_byte_index,
    input  logic [7:0]  s_byte_value,
    input  logic        s_sda_in,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_scl_level,
    output logic        m_sda_pull_low,
    output logic        m_busy_res,
    output logic        m_read_valid,
    output logic [2:0]  m_read_index,
    output logic [7:0]  m_read_byte,
    output logic        m_done_res,
    output logic        m_status
);

    cfg_t              cfg_reg;
    item_t             item;
    res_t              seq_res;
    res_t              out_res;
    logic              accept;
    logic              free;
    logic [BUF_AW-1:0] buf_addr;
    logic [7:0]        buf_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.dev_addr     <= DEV_ADDR_RST;
            cfg_reg.retry_lim    <= RETRY_LIM_RST;
            cfg_reg.ack_wait_lim <= ACK_WAIT_RST;
            cfg_reg.tpp          <= TPP_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_DEV_ADDR:  cfg_reg.dev_addr     <= cfg_wdata[6:0];
                CFG_RETRY_LIM: cfg_reg.retry_lim    <= cfg_wdata;
                CFG_ACK_WAIT:  cfg_reg.ack_wait_lim <= cfg_wdata;
                CFG_TPP:       cfg_reg.tpp          <= cfg_wdata[7:0];
                default:       cfg_reg.tpp          <= cfg_reg.tpp;
            endcase
        end
    end

    assign s_ready = free;
    assign accept  = s_valid && free;

    assign item.func       = func_t'(s_func);
    assign item.reg_addr   = s_reg_addr;
    assign item.count      = s_count;
    assign item.byte_index = s_byte_index;
    assign item.byte_value = s_byte_value;
    assign item.sda_in     = s_sda_in;

    i2cbm_wbuf u_wbuf (
        .aclk    (aclk),
        .wr_en   (accept && item.func == FUNC_LOAD),
        .wr_addr (item.byte_index[BUF_AW-1:0]),
        .wr_data (item.byte_value),
        .rd_addr (buf_addr),
        .rd_data (buf_data)
    );

    i2cbm_seq #(
        .MAX_BURST (MAX_BURST)
    ) u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (accept),
        .item     (item),
        .cfg      (cfg_reg),
        .buf_data (buf_data),
        .buf_addr (buf_addr),
        .res      (seq_res)
    );

    i2cbm_obuf u_obuf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (accept),
        .res_in  (seq_res),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .free    (free),
        .res_out (out_res)
    );

    assign m_scl_level    = out_res.scl_level;
    assign m_sda_pull_low = out_res.sda_pull_low;
    assign m_busy_res     = out_res.busy_res;
    assign m_read_valid   = out_res.read_valid;
    assign m_read_index   = out_res.read_index;
    assign m_read_byte    = out_res.read_byte;
    assign m_done_res     = out_res.done_res;
    assign m_status       = out_res.status;

endmodule

// ----- src/i2cbm_wbuf.sv -----
// eight-byte transmit buffer loaded by the load command
module i2cbm_wbuf
    import i2cbm_pkg::*;
(
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [BUF_AW-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic [BUF_AW-1:0] rd_addr,
    output logic [7:0]        rd_data
);

    logic [7:0] mem_reg [BUF_SLOTS];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // read every cycle; a byte written in the same cycle is passed straight through
    always_ff @(posedge aclk) begin
        if (wr_en && wr_addr == rd_addr) begin
            rd_data_reg <= wr_data;
        end else begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/i2cbm_seq.sv -----
// bus sequencer: state registers and the per-item next-state and line logic
module i2cbm_seq
    import i2cbm_pkg::*;
#(
    parameter int unsigned MAX_BURST = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  item_t             item,
    input  cfg_t              cfg,
    input  logic [7:0]        buf_data,
    output logic [BUF_AW-1:0] buf_addr,
    output res_t              res
);

    seq_state_t  st_reg, st_next;
    logic [7:0]  ph_reg, ph_next;
    logic [1:0]  q_reg, q_next;
    logic [3:0]  bc_reg, bc_next;
    logic [7:0]  sr_reg, sr_next;
    logic [3:0]  pos_reg, pos_next;
    logic [15:0] retry_reg, retry_next;
    logic [15:0] ackw_reg, ackw_next;
    logic        isrd_reg, isrd_next;
    logic [3:0]  blen_reg, blen_next;
    logic [7:0]  raddr_reg, raddr_next;
    logic        acks_reg, acks_next;
    logic        aerr_reg, aerr_next;

    logic [7:0]  tpp;
    logic [8:0]  ph_inc;
    logic [4:0]  pos_inc;
    logic [7:0]  rx_shift;
    logic        is_tx;
    logic        saturate;
    logic        scl_lvl;
    logic        pull_low;

    assign tpp      = (cfg.tpp == 8'd0) ? 8'd1 : cfg.tpp;
    assign ph_inc   = {1'b0, ph_reg} + 9'd1;
    assign pos_inc  = {1'b0, pos_reg} + 5'd1;
    assign rx_shift = {sr_reg[6:0], item.sda_in};
    assign is_tx    = (st_reg == ST_TXADDR) || (st_reg == ST_TXREG) ||
                      (st_reg == ST_TXRADDR) || (st_reg == ST_TXDATA);
    assign saturate = 32'(item.count) > MAX_BURST;

    // first data byte comes from slot zero, later ones from the next position;
    // the address holds for a whole byte slot, so the registered read is ready
    assign buf_addr = (st_reg == ST_TXREG) ? '0 : pos_inc[BUF_AW-1:0];

    // line levels follow the state held before this item
    always_comb begin
        scl_lvl  = (q_reg == 2'd1) || (q_reg == 2'd2);
        pull_low = 1'b0;
        unique case (st_reg)
            ST_IDLE: begin
                scl_lvl = 1'b1;
            end
            ST_START1, ST_START2: begin
                pull_low = q_reg[1];
            end
            ST_STOP: begin
                scl_lvl  = (q_reg != 2'd0);
                pull_low = !q_reg[1];
            end
            ST_TXADDR, ST_TXREG, ST_TXRADDR, ST_TXDATA: begin
                if (!bc_reg[3]) pull_low = !sr_reg[7];
            end
            ST_RXDATA: begin
                if (bc_reg[3]) pull_low = pos_inc < {1'b0, blen_reg};
            end
            default: begin
                scl_lvl = 1'b1;
            end
        endcase
    end

    always_comb begin
        st_next    = st_reg;
        ph_next    = ph_reg;
        q_next     = q_reg;
        bc_next    = bc_reg;
        sr_next    = sr_reg;
        pos_next   = pos_reg;
        retry_next = retry_reg;
        ackw_next  = ackw_reg;
        isrd_next  = isrd_reg;
        blen_next  = blen_reg;
        raddr_next = raddr_reg;
        acks_next  = acks_reg;
        aerr_next  = aerr_reg;

        res.scl_level    = scl_lvl;
        res.sda_pull_low = pull_low;
        res.read_valid   = 1'b0;
        res.read_index   = '0;
        res.read_byte    = '0;
        res.done_res     = 1'b0;
        res.status       = 1'b0;

        if (item.func == FUNC_LOAD) begin
            // buffer write only, sequencer holds
        end else if (item.func != FUNC_TICK) begin
            if (st_reg == ST_IDLE && item.count != 4'd0) begin
                blen_next  = saturate ? 4'(MAX_BURST) : item.count;
                raddr_next = item.reg_addr;
                isrd_next  = (item.func == FUNC_READ);
                st_next    = ST_START1;
                ph_next    = '0;
                q_next     = '0;
                bc_next    = '0;
                sr_next    = '0;
                pos_next   = '0;
                retry_next = '0;
                ackw_next  = '0;
                acks_next  = 1'b0;
                aerr_next  = 1'b0;
            end
        end else if (st_reg != ST_IDLE) begin
            if (is_tx && bc_reg[3] && q_reg == 2'd2) begin
                // acknowledge wait, sampled every tick
                if (!item.sda_in) begin
                    acks_next = 1'b1;
                    ph_next   = '0;
                    q_next    = 2'd3;
                end else if (ackw_reg >= cfg.ack_wait_lim) begin
                    acks_next = 1'b0;
                    ph_next   = '0;
                    q_next    = 2'd3;
                end else begin
                    ackw_next = ackw_reg + 16'd1;
                end
            end else begin
                if (st_reg == ST_RXDATA && !bc_reg[3] && q_reg == 2'd2 &&
                    ph_inc >= {1'b0, tpp}) begin
                    sr_next = rx_shift;
                    if (bc_reg == 4'd7) begin
                        res.read_valid = 1'b1;
                        res.read_index = pos_reg[2:0];
                        res.read_byte  = rx_shift;
                    end
                end
                if (ph_inc >= {1'b0, tpp}) begin
                    ph_next = '0;
                    if (q_reg != 2'd3) begin
                        q_next = q_reg + 2'd1;
                    end else begin
                        q_next = '0;
                        // end of bit slot
                        if (st_reg == ST_START1 || st_reg == ST_START2) begin
                            st_next = (st_reg == ST_START1) ? ST_TXADDR : ST_TXRADDR;
                            sr_next = {cfg.dev_addr, st_reg == ST_START2};
                            bc_next = '0;
                        end else if (st_reg == ST_STOP) begin
                            st_next       = ST_IDLE;
                            res.done_res  = 1'b1;
                            res.status    = aerr_reg;
                        end else if (is_tx) begin
                            if (!bc_reg[3]) begin
                                sr_next = {sr_reg[6:0], 1'b0};
                                bc_next = bc_reg + 4'd1;
                                if (bc_reg == 4'd7) begin
                                    ackw_next = '0;
                                    acks_next = 1'b0;
                                end
                            end else begin
                                bc_next = '0;
                                case (st_reg)
                                    ST_TXADDR: begin
                                        if (acks_reg) begin
                                            st_next = ST_TXREG;
                                            sr_next = raddr_reg;
                                        end else if (retry_reg >= cfg.retry_lim) begin
                                            aerr_next = 1'b1;
                                            st_next   = ST_STOP;
                                        end else begin
                                            retry_next = retry_reg + 16'd1;
                                            st_next    = ST_START1;
                                        end
                                    end
                                    ST_TXREG: begin
                                        pos_next = '0;
                                        if (isrd_reg) begin
                                            st_next = ST_START2;
                                        end else begin
                                            st_next = ST_TXDATA;
                                            sr_next = buf_data;
                                        end
                                    end
                                    ST_TXRADDR: begin
                                        pos_next = '0;
                                        sr_next  = '0;
                                        st_next  = ST_RXDATA;
                                    end
                                    default: begin
                                        pos_next = pos_inc[3:0];
                                        if (pos_inc >= {1'b0, blen_reg}) begin
                                            st_next = ST_STOP;
                                        end else begin
                                            sr_next = buf_data;
                                        end
                                    end
                                endcase
                            end
                        end else begin
                            // receive byte slots
                            if (!bc_reg[3]) begin
                                bc_next = bc_reg + 4'd1;
                            end else begin
                                bc_next  = '0;
                                pos_next = pos_inc[3:0];
                                sr_next  = '0;
                                if (pos_inc >= {1'b0, blen_reg}) st_next = ST_STOP;
                            end
                        end
                    end
                end else begin
                    ph_next = ph_inc[7:0];
                end
            end
        end

        res.busy_res = (st_next != ST_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg    <= ST_IDLE;
            ph_reg    <= '0;
            q_reg     <= '0;
            bc_reg    <= '0;
            sr_reg    <= '0;
            pos_reg   <= '0;
            retry_reg <= '0;
            ackw_reg  <= '0;
            isrd_reg  <= 1'b0;
            blen_reg  <= '0;
            raddr_reg <= '0;
            acks_reg  <= 1'b0;
            aerr_reg  <= 1'b0;
        end else if (step) begin
            st_reg    <= st_next;
            ph_reg    <= ph_next;
            q_reg     <= q_next;
            bc_reg    <= bc_next;
            sr_reg    <= sr_next;
            pos_reg   <= pos_next;
            retry_reg <= retry_next;
            ackw_reg  <= ackw_next;
            isrd_reg  <= isrd_next;
            blen_reg  <= blen_next;
            raddr_reg <= raddr_next;
            acks_reg  <= acks_next;
            aerr_reg  <= aerr_next;
        end
    end

endmodule

// ----- src/i2cbm_obuf.sv -----
// result register between the sequencer and the result channel
module i2cbm_obuf
    import i2cbm_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic load,
    input  res_t res_in,
    input  logic m_ready,
    output logic m_valid,
    output logic free,
    output res_t res_out
);

    logic valid_reg, valid_next;
    res_t res_reg;

    // slot frees up in the same cycle the held item is taken
    assign free       = !valid_reg || m_ready;
    assign valid_next = load ? 1'b1 : (m_ready ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res_in;
        end
    end

    assign m_valid = valid_reg;
    assign res_out = res_reg;

endmodule

// ----- tb/i2c_register_burst_master_tb.sv -----
// self-checking testbench for the i2c register burst master
`timescale 1ns / 100ps

module i2c_register_burst_master_tb;
    import i2cbm_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_func = '0;
    logic [7:0]  s_reg_addr = '0;
    logic [3:0]  s_count = '0;
    logic [2:0]  s_byte_index = '0;
    logic [7:0]  s_byte_value = '0;
    logic        s_sda_in = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_scl_level;
    logic        m_sda_pull_low;
    logic        m_busy_res;
    logic        m_read_valid;
    logic [2:0]  m_read_index;
    logic [7:0]  m_read_byte;
    logic        m_done_res;
    logic        m_status;

    i2c_register_burst_master u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_reg_addr     (s_reg_addr),
        .s_count        (s_count),
        .s_byte_index   (s_byte_index),
        .s_byte_value   (s_byte_value),
        .s_sda_in       (s_sda_in),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_scl_level    (m_scl_level),
        .m_sda_pull_low (m_sda_pull_low),
        .m_busy_res     (m_busy_res),
        .m_read_valid   (m_read_valid),
        .m_read_index   (m_read_index),
        .m_read_byte    (m_read_byte),
        .m_done_res     (m_done_res),
        .m_status       (m_status)
    );

    always #4 aclk = ~aclk;

    // bus sequencer mirror, starts in its reset state
    logic [6:0]  c_dev = DEV_ADDR_RST;
    logic [15:0] c_retry = RETRY_LIM_RST;
    logic [15:0] c_ackw = ACK_WAIT_RST;
    logic [7:0]  c_tpp = TPP_RST;
    seq_state_t  st = ST_IDLE;
    logic [7:0]  ph_cnt = '0;
    logic [1:0]  qtr = '0;
    logic [3:0]  bit_cnt = '0;
    logic [7:0]  shreg = '0;
    logic [3:0]  pos = '0;
    logic [15:0] retries = '0;
    logic [15:0] ack_wait = '0;
    logic        rd_burst = 1'b0;
    logic [3:0]  blen = '0;
    logic [7:0]  raddr = '0;
    logic        ack_ok = 1'b0;
    logic        nack_err = 1'b0;
    logic [7:0]  tx_buf [BUF_SLOTS];

    res_t expected_bus_q [$];

    int unsigned src_idle_pct = 11;
    int unsigned sink_idle_pct = 64;
    int unsigned err_cnt = 0;
    int unsigned res_cnt = 0;
    int unsigned item_cnt = 0;
    int unsigned rd_cnt = 0;
    int unsigned done_cnt = 0;
    int unsigned nack_burst_cnt = 0;
    int unsigned cycle_cnt = 0;

    function automatic logic tx_state(seq_state_t s);
        return s == ST_TXADDR || s == ST_TXREG || s == ST_TXRADDR || s == ST_TXDATA;
    endfunction

    // one item through the sequencer: line levels come from the state before the item
    function automatic res_t bus_step(item_t it);
        res_t r;
        logic [7:0] tpp;
        logic slot_over;
        r = '0;
        r.scl_level = (qtr == 2'd1 || qtr == 2'd2);
        case (st)
            ST_IDLE: r.scl_level = 1'b1;
            ST_START1, ST_START2: r.sda_pull_low = (qtr >= 2'd2);
            ST_STOP: begin
                r.scl_level = (qtr >= 2'd1);
                r.sda_pull_low = (qtr <= 2'd1);
            end
            ST_RXDATA: begin
                // master acks every byte but the last
                if (bit_cnt >= 4'd8)
                    r.sda_pull_low = ({1'b0, pos} + 5'd1 < {1'b0, blen});
            end
            default: begin
                if (bit_cnt < 4'd8)
                    r.sda_pull_low = ~shreg[7];
            end
        endcase

        tpp = (c_tpp == 8'd0) ? 8'd1 : c_tpp;
        slot_over = 1'b0;
        if (it.func == FUNC_LOAD) begin
            tx_buf[it.byte_index] = it.byte_value;
        end else if (it.func != FUNC_TICK) begin
            if (st == ST_IDLE && it.count != 4'd0) begin
                blen = (it.count > 4'd8) ? 4'd8 : it.count;
                raddr = it.reg_addr;
                rd_burst = (it.func == FUNC_READ);
                st = ST_START1;
                ph_cnt = '0;
                qtr = '0;
                bit_cnt = '0;
                shreg = '0;
                pos = '0;
                retries = '0;
                ack_wait = '0;
                ack_ok = 1'b0;
                nack_err = 1'b0;
            end
        end else if (st != ST_IDLE) begin
            if (tx_state(st) && bit_cnt >= 4'd8 && qtr == 2'd2) begin
                // ack bit holds scl high until sda goes low or the wait runs out
                if (!it.sda_in) begin
                    ack_ok = 1'b1;
                    ph_cnt = '0;
                    qtr = 2'd3;
                end else if (ack_wait >= c_ackw) begin
                    ack_ok = 1'b0;
                    ph_cnt = '0;
                    qtr = 2'd3;
                end else begin
                    ack_wait = ack_wait + 16'd1;
                end
            end else begin
                if (st == ST_RXDATA && bit_cnt < 4'd8 && qtr == 2'd2 &&
                    {1'b0, ph_cnt} + 9'd1 >= {1'b0, tpp}) begin
                    shreg = {shreg[6:0], it.sda_in};
                    if (bit_cnt == 4'd7) begin
                        r.read_valid = 1'b1;
                        r.read_index = pos[2:0];
                        r.read_byte = shreg;
                    end
                end
                ph_cnt = ph_cnt + 8'd1;
                if (ph_cnt >= tpp) begin
                    ph_cnt = '0;
                    slot_over = (qtr == 2'd3);
                    qtr = qtr + 2'd1;
                end
            end
        end

        if (slot_over) begin
            case (st)
                ST_START1: begin
                    st = ST_TXADDR;
                    shreg = {c_dev, 1'b0};
                    bit_cnt = '0;
                end
                ST_START2: begin
                    st = ST_TXRADDR;
                    shreg = {c_dev, 1'b1};
                    bit_cnt = '0;
                end
                ST_STOP: begin
                    st = ST_IDLE;
                    r.done_res = 1'b1;
                    r.status = nack_err;
                end
                ST_RXDATA: begin
                    if (bit_cnt < 4'd8) begin
                        bit_cnt = bit_cnt + 4'd1;
                    end else begin
                        bit_cnt = '0;
                        pos = pos + 4'd1;
                        shreg = '0;
                        if (pos >= blen)
                            st = ST_STOP;
                    end
                end
                default: begin
                    if (bit_cnt < 4'd8) begin
                        shreg = {shreg[6:0], 1'b0};
                        bit_cnt = bit_cnt + 4'd1;
                        if (bit_cnt == 4'd8) begin
                            ack_wait = '0;
                            ack_ok = 1'b0;
                        end
                    end else begin
                        bit_cnt = '0;
                        case (st)
                            ST_TXADDR: begin
                                // only the first address phase retries on no ack
                                if (ack_ok) begin
                                    st = ST_TXREG;
                                    shreg = raddr;
                                end else if (retries >= c_retry) begin
                                    nack_err = 1'b1;
                                    st = ST_STOP;
                                end else begin
                                    retries = retries + 16'd1;
                                    st = ST_START1;
                                end
                            end
                            ST_TXREG: begin
                                pos = '0;
                                if (rd_burst) begin
                                    st = ST_START2;
                                end else begin
                                    st = ST_TXDATA;
                                    shreg = tx_buf[0];
                                end
                            end
                            ST_TXRADDR: begin
                                pos = '0;
                                shreg = '0;
                                st = ST_RXDATA;
                            end
                            default: begin
                                pos = pos + 4'd1;
                                if (pos >= blen)
                                    st = ST_STOP;
                                else
                                    shreg = tx_buf[pos[2:0]];
                            end
                        endcase
                    end
                end
            endcase
        end
        r.busy_res = (st != ST_IDLE);
        return r;
    endfunction

    function automatic item_t make_item(func_t f);
        item_t it;
        it.func = f;
        it.reg_addr = 8'($urandom_range(255));
        it.count = 4'($urandom_range(15));
        it.byte_index = 3'($urandom_range(7));
        it.byte_value = 8'($urandom_range(255));
        it.sda_in = 1'($urandom_range(1));
        return it;
    endfunction

    // slave behavior: acks mostly when present, random data bits otherwise
    function automatic logic pick_sda(logic present);
        if (tx_state(st) && bit_cnt >= 4'd8 && qtr == 2'd2)
            return present ? ($urandom_range(99) >= 80) : 1'b1;
        return 1'($urandom_range(1));
    endfunction

    task automatic report_mismatch(string field, int unsigned want, int unsigned got);
        err_cnt++;
        $display("mismatch at result %0d: %s expected %0h got %0h",
                 res_cnt, field, want, got);
    endtask

    task automatic push_item(item_t it);
        int unsigned gap;
        res_t r;
        gap = 0;
        while ($urandom_range(99) < src_idle_pct)
            gap++;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_func <= it.func;
        s_reg_addr <= it.reg_addr;
        s_count <= it.count;
        s_byte_index <= it.byte_index;
        s_byte_value <= it.byte_value;
        s_sda_in <= it.sda_in;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        r = bus_step(it);
        expected_bus_q.push_back(r);
        item_cnt++;
        if (r.read_valid)
            rd_cnt++;
        if (r.done_res) begin
            done_cnt++;
            if (r.status)
                nack_burst_cnt++;
        end
    endtask

    task automatic push_begin(func_t f, logic [7:0] reg_a, logic [3:0] cnt);
        item_t it;
        it = make_item(f);
        it.reg_addr = reg_a;
        it.count = cnt;
        push_item(it);
    endtask

    task automatic tick_until_idle(logic present, int unsigned noise_pct);
        item_t it;
        while (st != ST_IDLE) begin
            if ($urandom_range(99) < noise_pct) begin
                it = make_item(func_t'($urandom_range(3)));
            end else begin
                it = make_item(FUNC_TICK);
                it.sda_in = pick_sda(present);
            end
            push_item(it);
        end
    endtask

    task automatic wait_quiet();
        s_valid <= 1'b0;
        while (expected_bus_q.size() != 0)
            @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            CFG_DEV_ADDR:  c_dev = val[6:0];
            CFG_RETRY_LIM: c_retry = val;
            CFG_ACK_WAIT:  c_ackw = val;
            default:       c_tpp = val[7:0];
        endcase
    endtask

    // upper data bits carry junk that the narrow registers must drop
    task automatic set_bus_cfg(logic [6:0] dev, logic [15:0] retry, logic [15:0] ackw,
                               logic [7:0] tpp);
        logic [8:0] junk_hi;
        logic [7:0] junk_lo;
        junk_hi = 9'($urandom_range(511));
        junk_lo = 8'($urandom_range(255));
        write_reg(CFG_DEV_ADDR, {junk_hi, dev});
        write_reg(CFG_RETRY_LIM, retry);
        write_reg(CFG_ACK_WAIT, ackw);
        write_reg(CFG_TPP, {junk_lo, tpp});
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic test_buffer_load();
        logic [7:0] fill [BUF_SLOTS];
        item_t it;
        fill = '{8'h00, 8'hFF, 8'hA5, 8'h5A, 8'h01, 8'h80, 8'h7F, 8'hFE};
        for (int i = 0; i < BUF_SLOTS; i++) begin
            it = make_item(FUNC_LOAD);
            it.byte_index = 3'(i);
            it.byte_value = fill[i];
            push_item(it);
        end
    endtask

    task automatic test_idle_commands();
        item_t it;
        it = make_item(FUNC_TICK);
        it.sda_in = 1'b0;
        push_item(it);
        it.sda_in = 1'b1;
        push_item(it);
        // zero length bursts are dropped
        push_begin(FUNC_WRITE, 8'hFF, 4'd0);
        push_begin(FUNC_READ, 8'h00, 4'd0);
    endtask

    task automatic test_write_burst();
        item_t it;
        push_begin(FUNC_WRITE, 8'hFF, 4'd1);
        repeat (3) push_item(make_item(FUNC_TICK));
        // begin while busy is ignored, load while busy lands at once
        push_begin(FUNC_READ, 8'h12, 4'd4);
        it = make_item(FUNC_LOAD);
        it.byte_index = 3'd0;
        it.byte_value = 8'h3C;
        push_item(it);
        tick_until_idle(1'b1, 0);
    endtask

    // count above the burst limit saturates
    task automatic test_read_burst();
        push_begin(FUNC_READ, 8'h00, 4'd12);
        tick_until_idle(1'b1, 0);
    endtask

    task automatic test_address_nack();
        wait_quiet();
        set_bus_cfg(7'd0, 16'd1, 16'd2, 8'd1);
        push_begin(FUNC_WRITE, 8'h40, 4'd3);
        tick_until_idle(1'b0, 0);
    endtask

    task automatic test_zero_limits();
        wait_quiet();
        set_bus_cfg(7'h55, 16'd0, 16'd0, 8'd0);
        push_begin(FUNC_READ, 8'h81, 4'd1);
        tick_until_idle(1'b0, 0);
    endtask

    task automatic test_limit_extremes();
        wait_quiet();
        set_bus_cfg(7'h7F, 16'hFFFF, 16'hFFFF, 8'd1);
        push_begin(FUNC_WRITE, 8'hC3, 4'd1);
        tick_until_idle(1'b1, 0);
    endtask

    task automatic run_bursts(int unsigned n_items, int unsigned src_pct, int unsigned sink_pct);
        int unsigned start_cnt;
        logic present;
        logic [3:0] cnt;
        src_idle_pct = src_pct;
        sink_idle_pct = sink_pct;
        start_cnt = item_cnt;
        while (item_cnt - start_cnt < n_items) begin
            present = ($urandom_range(99) >= 15);
            repeat ($urandom_range(3))
                push_item(make_item(FUNC_LOAD));
            cnt = ($urandom_range(99) < 70) ? 4'($urandom_range(1, 2))
                                            : 4'($urandom_range(15));
            push_begin($urandom_range(1) ? FUNC_WRITE : FUNC_READ,
                       8'($urandom_range(255)), cnt);
            tick_until_idle(present, 5);
            if ($urandom_range(99) < 30) begin
                wait_quiet();
                set_bus_cfg(7'($urandom_range(127)), 16'($urandom_range(3)),
                            16'($urandom_range(6)), 8'($urandom_range(2)));
            end
        end
    endtask

    task automatic test_random_traffic();
        run_bursts(60, 11, 64);
        run_bursts(60, 64, 11);
        run_bursts(60, 0, 0);
    endtask

    // slowest scl: only the first quarter edge is reached, the block stays busy
    task automatic test_slow_bus();
        item_t it;
        wait_quiet();
        set_bus_cfg(7'($urandom_range(127)), 16'd1000, 16'd5000, 8'd255);
        push_begin(FUNC_READ, 8'($urandom_range(255)), 4'd1);
        repeat (260) begin
            it = make_item(FUNC_TICK);
            it.sda_in = pick_sda(1'b1);
            push_item(it);
        end
    endtask

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    always @(posedge aclk) begin : result_check
        res_t want;
        res_t got;
        if (aresetn && m_valid && m_ready) begin
            got = {m_scl_level, m_sda_pull_low, m_busy_res, m_read_valid, m_read_index,
                   m_read_byte, m_done_res, m_status};
            if (expected_bus_q.size() == 0) begin
                report_mismatch("item with nothing pending", 0, 32'(got));
            end else begin
                want = expected_bus_q.pop_front();
                if (want.scl_level !== got.scl_level)
                    report_mismatch("scl_level", 32'(want.scl_level),
                                    32'(got.scl_level));
                if (want.sda_pull_low !== got.sda_pull_low)
                    report_mismatch("sda_pull_low", 32'(want.sda_pull_low),
                                    32'(got.sda_pull_low));
                if (want.busy_res !== got.busy_res)
                    report_mismatch("busy_res", 32'(want.busy_res), 32'(got.busy_res));
                if (want.read_valid !== got.read_valid)
                    report_mismatch("read_valid", 32'(want.read_valid),
                                    32'(got.read_valid));
                if (want.read_index !== got.read_index)
                    report_mismatch("read_index", 32'(want.read_index),
                                    32'(got.read_index));
                if (want.read_byte !== got.read_byte)
                    report_mismatch("read_byte", 32'(want.read_byte), 32'(got.read_byte));
                if (want.done_res !== got.done_res)
                    report_mismatch("done_res", 32'(want.done_res), 32'(got.done_res));
                if (want.status !== got.status)
                    report_mismatch("status", 32'(want.status), 32'(got.status));
            end
            res_cnt++;
        end
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d items still pending",
                     cycle_cnt, expected_bus_q.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_buffer_load();
        test_idle_commands();
        test_write_burst();
        test_read_burst();
        test_address_nack();
        test_zero_limits();
        test_limit_extremes();
        test_random_traffic();
        test_slow_bus();

        wait_quiet();
        repeat (4) @(posedge aclk);
        $display("%0d items checked: %0d read bytes, %0d bursts closed, %0d without address ack",
                 res_cnt, rd_cnt, done_cnt, nack_burst_cnt);
        $display("config swept from zero limits to full range, scl from 1 to 255 ticks per phase");
        if (err_cnt == 0 && expected_bus_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
